@@ src/mau_pkg.sv @@
// Package for the modular arithmetic unit: operation codes, states and reset constants.
`default_nettype none
package mau_pkg;

   localparam int unsigned VALUE_WIDTH_DEF = 32;
   localparam int unsigned EXP_WIDTH_DEF   = 64;
   localparam int unsigned RESULT_WIDTH    = 32;
   localparam int unsigned KIND_WIDTH      = 4;
   localparam logic [63:0] MODULUS_RESET   = 64'd1000000007;

   typedef enum logic [KIND_WIDTH-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_INV = 4'd4,
      OP_NEG = 4'd5,
      OP_POW = 4'd6,
      OP_INC = 4'd7,
      OP_DEC = 4'd8
   } op_type;

   // Requests to the shared modular reducer and its status.
   typedef struct packed {
      logic start;
   } red_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } red_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_EU_DIV,
      ST_EU_MUL,
      ST_EU_UPD,
      ST_INV_DONE,
      ST_POW_STEP,
      ST_POW_SQ,
      ST_MUL_FIN,
      ST_DONE
   } state_type;

endpackage : mau_pkg
`default_nettype wire

@@ src/mau_reducer.sv @@
// Shared restoring reducer: computes quotient and remainder of a wide value by a divisor, one bit per cycle.
`default_nettype none
module mau_reducer #(
   parameter int unsigned VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mau_pkg::red_ctl_type       ctl,
   input  wire logic [2*VALUE_WIDTH-1:0]   dividend,
   input  wire logic [VALUE_WIDTH-1:0]     divisor,
   output mau_pkg::red_sts_type            sts,
   output logic [VALUE_WIDTH-1:0]          remainder,
   output logic [2*VALUE_WIDTH-1:0]        quotient
);
   import mau_pkg::*;

   localparam int unsigned DW = 2 * VALUE_WIDTH;
   localparam int unsigned CW = $clog2(DW + 1);

   logic [DW-1:0]        num_ff, num_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [VALUE_WIDTH:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [VALUE_WIDTH+1:0] trial;
   logic [VALUE_WIDTH:0]   shifted;

   // One restoring step: shift in the next dividend bit and subtract if it fits.
   always_comb begin
      shifted = {rem_ff[VALUE_WIDTH-1:0], num_ff[DW-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], 1'b0};
         if (!trial[VALUE_WIDTH+1]) begin
            rem_in = trial[VALUE_WIDTH:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff[VALUE_WIDTH-1:0];
   assign quotient  = quo_ff;

   // A finished reduction always leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < {1'b0, div_ff}))
      else $error("reducer remainder not below divisor");

   // Done comes only at the end of a busy pass.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("reducer done without busy");

   // The unit is never busy and done together.
   assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("reducer busy and done at once");

endmodule : mau_reducer
`default_nettype wire

@@ src/modular_arithmetic_unit.sv @@
// Top level of the modular arithmetic unit: sequencer around one multiplier and one reducer.
//
// Channel   | Ports                                           | Direction
// request   | start, busy, req_kind, req_operand_a/_b, req_exponent | in (busy out)
// response  | rsp_valid, rsp_result, rsp_no_inverse           | out
// config    | csr_write, csr_modulus                          | in
//
// Every reduction passes through a shared bit-serial reducer.
// Add, sub, negate, increment, decrement: three reductions.
// Multiply: three reductions as well; power: up to 2*EXP_WIDTH multiplies, each a reduction.
// Inverse: one division and one multiply reduction per Euclid step.
// Reset is synchronous; busy rises once start is taken and stays high through the response cycle.
// The response is shown for one cycle with rsp_valid; the receiver cannot stall.
`default_nettype none
module modular_arithmetic_unit #(
   parameter int unsigned VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEF,
   parameter int unsigned EXP_WIDTH   = mau_pkg::EXP_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [mau_pkg::KIND_WIDTH-1:0]    req_kind,
   input  wire logic [VALUE_WIDTH-1:0]            req_operand_a,
   input  wire logic [VALUE_WIDTH-1:0]            req_operand_b,
   input  wire logic signed [EXP_WIDTH-1:0]       req_exponent,
   output logic                                   rsp_valid,
   output logic [mau_pkg::RESULT_WIDTH-1:0]       rsp_result,
   output logic                                   rsp_no_inverse,
   input  wire logic                              csr_write,
   input  wire logic [VALUE_WIDTH-1:0]            csr_modulus
);
   import mau_pkg::*;

   localparam int unsigned VW = VALUE_WIDTH;
   localparam int unsigned DW = 2 * VALUE_WIDTH;

   state_type state_ff, state_in;

   logic [VW-1:0]        mod_ff;
   logic [VW-1:0]        m_ff, m_in;
   logic [KIND_WIDTH-1:0] kind_ff, kind_in;
   logic [VW-1:0]        a_ff, a_in;
   logic [VW-1:0]        b_ff, b_in;
   logic [EXP_WIDTH-1:0] e_ff, e_in;
   logic [VW-1:0]        r0_ff, r0_in, r1_ff, r1_in;
   logic [VW-1:0]        t0_ff, t0_in, t1_ff, t1_in;
   logic [VW-1:0]        q_ff, q_in;
   logic [VW-1:0]        acc_ff, acc_in;
   logic [VW-1:0]        res_ff, res_in;
   logic                 flag_ff, flag_in;
   logic                 out_ff, out_in;

   red_ctl_type          rctl;
   red_sts_type          rsts;
   logic [DW-1:0]        rdividend;
   logic [VW-1:0]        rdivisor;
   logic [VW-1:0]        rrem;
   logic [DW-1:0]        rquo;

   logic [VW-1:0]        mul_x, mul_y;
   logic [DW-1:0]        product;
   logic [VW:0]          tsub;
   logic [VW-1:0]        one_mod;
   logic                 e_neg;
   logic [EXP_WIDTH-1:0] e_mag;

   mau_reducer #(.VALUE_WIDTH(VALUE_WIDTH)) u_reducer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rctl),
      .dividend  (rdividend),
      .divisor   (rdivisor),
      .sts       (rsts),
      .remainder (rrem),
      .quotient  (rquo)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET[VW-1:0];
      end else if (csr_write) begin
         mod_ff <= csr_modulus;
      end
   end

   // Shared multiplier.
   assign product = DW'(mul_x) * DW'(mul_y);
   assign one_mod = (m_ff == VW'(1)) ? '0 : VW'(1);
   assign e_neg   = req_exponent[EXP_WIDTH-1];
   assign e_mag   = e_neg ? (~req_exponent + EXP_WIDTH'(1)) : req_exponent;
   assign tsub    = {1'b0, t0_ff} + {1'b0, m_ff} - {1'b0, rrem};

   // Multiplier operand selection.
   always_comb begin
      mul_x = acc_ff;
      mul_y = a_ff;
      case (state_ff)
         ST_EU_MUL: begin
            mul_x = q_ff;
            mul_y = t1_ff;
         end
         ST_POW_SQ: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
         ST_MUL_FIN: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = acc_ff;
            mul_y = a_ff;
         end
      endcase
   end

   // Next state and datapath.
   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      kind_in   = kind_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      q_in      = q_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      flag_in   = flag_ff;
      out_in    = 1'b0;
      rctl.start = 1'b0;
      rdividend = DW'(a_ff);
      rdivisor  = m_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               m_in     = (mod_ff == '0) ? VW'(1) : mod_ff;
               kind_in  = req_kind;
               a_in     = req_operand_a;
               b_in     = req_operand_b;
               e_in     = e_mag;
               flag_in  = e_neg;
               state_in = ST_RED_A;
               rctl.start = 1'b1;
               rdividend = DW'(req_operand_a);
               rdivisor  = (mod_ff == '0) ? VW'(1) : mod_ff;
            end
         end
         ST_RED_A: begin
            if (rsts.done) begin
               a_in = rrem;
               rctl.start = 1'b1;
               rdividend = DW'(b_ff);
               state_in = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (rsts.done) begin
               b_in = rrem;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in = '0;
            acc_in = one_mod;
            rctl.start = 1'b1;
            state_in = ST_DONE;
            case (kind_ff)
               OP_ADD: rdividend = DW'(a_ff) + DW'(b_ff);
               OP_SUB: rdividend = DW'(a_ff) + DW'(m_ff) - DW'(b_ff);
               OP_NEG: rdividend = DW'(m_ff) - DW'(a_ff);
               OP_INC: rdividend = DW'(a_ff) + DW'(1);
               OP_DEC: rdividend = (a_ff == '0) ? DW'(m_ff) - DW'(1) : DW'(a_ff) - DW'(1);
               OP_MUL: begin
                  rctl.start = 1'b0;
                  state_in = ST_MUL_FIN;
               end
               OP_DIV, OP_INV: begin
                  rctl.start = 1'b0;
                  r0_in = m_ff;
                  r1_in = (kind_ff == OP_DIV) ? b_ff : a_ff;
                  t0_in = '0;
                  t1_in = one_mod;
                  state_in = ST_EU_DIV;
               end
               OP_POW: begin
                  rctl.start = 1'b0;
                  if (flag_ff) begin
                     r0_in = m_ff;
                     r1_in = a_ff;
                     t0_in = '0;
                     t1_in = one_mod;
                     state_in = ST_EU_DIV;
                  end else begin
                     state_in = ST_POW_STEP;
                  end
               end
               default: rdividend = '0;
            endcase
            flag_in = 1'b0;
            if (kind_ff == OP_POW) flag_in = flag_ff;
         end
         ST_EU_DIV: begin
            // Start r0 / r1, or finish when r1 reaches zero.
            if (!rsts.busy && !rsts.done) begin
               if (r1_ff == '0) begin
                  state_in = ST_INV_DONE;
               end else begin
                  rctl.start = 1'b1;
                  rdividend = DW'(r0_ff);
                  rdivisor  = r1_ff;
               end
            end else if (rsts.done) begin
               q_in  = rquo[VW-1:0];
               r0_in = r1_ff;
               r1_in = rrem;
               state_in = ST_EU_MUL;
            end
         end
         ST_EU_MUL: begin
            // q < m after the first step; reduce q*t1 modulo m.
            if (!rsts.busy && !rsts.done) begin
               rctl.start = 1'b1;
               rdividend = product;
            end else if (rsts.done) begin
               state_in = ST_EU_UPD;
            end
         end
         ST_EU_UPD: begin
            t0_in = t1_ff;
            t1_in = (tsub >= {1'b0, m_ff}) ? VW'(tsub - {1'b0, m_ff}) : tsub[VW-1:0];
            state_in = ST_EU_DIV;
         end
         ST_INV_DONE: begin
            flag_in = 1'b0;
            if (r0_ff != VW'(1)) begin
               flag_in = 1'b1;
               res_in = '0;
               state_in = ST_DONE;
            end else if (kind_ff == OP_INV) begin
               res_in = t0_ff;
               state_in = ST_DONE;
            end else if (kind_ff == OP_DIV) begin
               b_in = t0_ff;
               state_in = ST_MUL_FIN;
            end else begin
               a_in = t0_ff;
               acc_in = one_mod;
               state_in = ST_POW_STEP;
            end
         end
         ST_POW_STEP: begin
            // Multiply the accumulator by the base when the low exponent bit is set; finish when the exponent is zero.
            if (!rsts.busy && !rsts.done) begin
               if (e_ff == '0) begin
                  res_in = acc_ff;
                  state_in = ST_DONE;
               end else if (e_ff[0]) begin
                  rctl.start = 1'b1;
                  rdividend = product;
               end else begin
                  state_in = ST_POW_SQ;
               end
            end else if (rsts.done) begin
               acc_in = rrem;
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            if (!rsts.busy && !rsts.done) begin
               rctl.start = 1'b1;
               rdividend = product;
            end else if (rsts.done) begin
               a_in = rrem;
               e_in = e_ff >> 1;
               state_in = ST_POW_STEP;
            end
         end
         ST_MUL_FIN: begin
            if (!rsts.busy && !rsts.done) begin
               rctl.start = 1'b1;
               rdividend = product;
            end else if (rsts.done) begin
               res_in = rrem;
               out_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            // Simple ops end with a reduction; others arrive with a ready result.
            if (rsts.done) begin
               res_in = rrem;
               out_in = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsts.busy) begin
               out_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
      m_ff    <= m_in;
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      e_ff    <= e_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      q_ff    <= q_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      flag_ff <= flag_in;
   end

   assign busy           = (state_ff != ST_IDLE) || out_ff;
   assign rsp_valid      = out_ff;
   assign rsp_result     = RESULT_WIDTH'(res_ff);
   assign rsp_no_inverse = flag_ff;

   // A response always carries a residue below the working modulus.
   assert property (@(posedge clock) disable iff (reset)
      out_ff |-> (res_ff < m_ff))
      else $error("result not reduced");

   // No inverse means the result is zero.
   assert property (@(posedge clock) disable iff (reset)
      (out_ff && flag_ff) |-> (res_ff == '0))
      else $error("flagged result not zero");

   // The reducer is idle whenever the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsts.busy)
      else $error("reducer busy while idle");

endmodule : modular_arithmetic_unit
`default_nettype wire

@@ verif/modular_arithmetic_unit_checker.sv @@
// Checker for the modular arithmetic unit: watches both channels and the modulus port.
`timescale 1ns / 1ps
module modular_arithmetic_unit_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [3:0]         req_kind,
   input  wire logic [31:0]        req_operand_a,
   input  wire logic [31:0]        req_operand_b,
   input  wire logic signed [63:0] req_exponent,
   input  wire logic               rsp_valid,
   input  wire logic [31:0]        rsp_result,
   input  wire logic               rsp_no_inverse,
   input  wire logic               csr_write,
   input  wire logic [31:0]        csr_modulus,
   output int                      fail_count,
   output int                      pending
);
   import mau_pkg::*;

   typedef struct {
      logic [31:0] result;
      logic        no_inverse;
   } answer_type;

   answer_type  answers[$];
   logic [31:0] modulus_copy;

   function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
      return (x * y) % m;
   endfunction

   // Extended Euclid; returns 1 when the inverse of a modulo m exists.
   function automatic bit invmod(longint unsigned a, longint unsigned m,
                                 output longint unsigned inv);
      longint unsigned r0, r1, r2, t0, t1, t2, q;
      r0 = m; r1 = a; t0 = 0; t1 = 1 % m;
      while (r1 != 0) begin
         q  = r0 / r1;
         r2 = r0 - q * r1;
         t2 = (t0 + m - mulmod(q % m, t1, m)) % m;
         r0 = r1; r1 = r2;
         t0 = t1; t1 = t2;
      end
      inv = (r0 == 1) ? t0 % m : 0;
      return r0 == 1;
   endfunction

   function automatic longint unsigned powmod(longint unsigned b, logic [63:0] e,
                                              longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      while (e != 0) begin
         if (e[0]) r = mulmod(r, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic answer_type compute_answer(logic [3:0] kind, logic [31:0] op_a,
                                                 logic [31:0] op_b, logic [63:0] ev,
                                                 logic [31:0] modv);
      answer_type      ans;
      longint unsigned m, a, b, inv, res;
      logic [63:0]     mag;
      m = modv;
      if (m == 0) m = 1;
      a = op_a % m;
      b = op_b % m;
      res = 0;
      ans.no_inverse = 1'b0;
      case (kind)
         OP_ADD: res = (a + b) % m;
         OP_SUB: res = (a + m - b) % m;
         OP_MUL: res = mulmod(a, b, m);
         OP_DIV: begin
            if (invmod(b, m, inv)) res = mulmod(a, inv, m);
            else ans.no_inverse = 1'b1;
         end
         OP_INV: begin
            if (invmod(a, m, inv)) res = inv;
            else ans.no_inverse = 1'b1;
         end
         OP_NEG: res = (m - a) % m;
         OP_POW: begin
            if (ev[63]) begin
               // Two's complement negation gives 2^63 for the most negative value.
               mag = -ev;
               if (invmod(a, m, inv)) res = powmod(inv, mag, m);
               else ans.no_inverse = 1'b1;
            end else begin
               res = powmod(a, ev, m);
            end
         end
         OP_INC: res = (a + 1) % m;
         OP_DEC: res = (a == 0) ? m - 1 : a - 1;
         default: res = 0;
      endcase
      ans.result = res[31:0];
      return ans;
   endfunction

   assign pending = answers.size();

   // Track the modulus, queue expected answers and compare responses.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         modulus_copy <= MODULUS_RESET[31:0];
         fail_count   <= 0;
         answers.delete();
      end else begin
         if (rsp_valid) begin
            if (answers.size() == 0) begin
               $display("%0t: response with no request waiting: result %0d no_inverse %0b",
                        $time, rsp_result, rsp_no_inverse);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (want.result !== rsp_result || want.no_inverse !== rsp_no_inverse) begin
                  $display("%0t: mismatch: expected result %0d no_inverse %0b, got %0d %0b",
                           $time, want.result, want.no_inverse, rsp_result, rsp_no_inverse);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            answers.push_back(compute_answer(req_kind, req_operand_a, req_operand_b,
                                             req_exponent, modulus_copy));
         if (csr_write) modulus_copy <= csr_modulus;
      end
   end
endmodule

@@ verif/modular_arithmetic_unit_test.sv @@
// Testbench top for the modular arithmetic unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module modular_arithmetic_unit_test;
   import mau_pkg::*;

   localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
   localparam logic [3:0] KIND_UNUSED_HI = 4'd15;
   localparam logic [63:0] EXP_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] EXP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   logic               clock, reset, start, busy;
   logic [3:0]         req_kind;
   logic [31:0]        req_operand_a, req_operand_b;
   logic signed [63:0] req_exponent;
   logic               rsp_valid, rsp_no_inverse;
   logic [31:0]        rsp_result;
   logic               csr_write;
   logic [31:0]        csr_modulus;
   int                 fail_count, pending;
   bit                 quiet;
   logic [31:0]        modulus_now;

   modular_arithmetic_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_exponent(req_exponent), .rsp_valid(rsp_valid), .rsp_result(rsp_result),
      .rsp_no_inverse(rsp_no_inverse), .csr_write(csr_write), .csr_modulus(csr_modulus)
   );

   modular_arithmetic_unit_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_exponent(req_exponent), .rsp_valid(rsp_valid), .rsp_result(rsp_result),
      .rsp_no_inverse(rsp_no_inverse), .csr_write(csr_write), .csr_modulus(csr_modulus),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Issue one request: optional idle burst, wait for the unit to be free, hold for one edge.
   task automatic issue(logic [3:0] kind, logic [31:0] a, logic [31:0] b, logic [63:0] e);
      if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clock);
      while (busy) @(negedge clock);
      start         <= 1'b1;
      req_kind      <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      req_exponent  <= e;
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Wait until every response is back and the unit is idle, then load a new modulus.
   task automatic set_modulus(logic [31:0] value);
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write   <= 1'b1;
      csr_modulus <= value;
      modulus_now = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 20);
         1: return (modulus_now == 0) ? 0 : modulus_now - $urandom_range(1, 3);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_exponent();
      logic [63:0] e;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      e = 64'($urandom_range(0, 4095));
      return ($urandom_range(0, 2) == 0) ? -e : e;
   endfunction

   task automatic random_batch(int count);
      logic [3:0] kind;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0)
            kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         else if ($urandom_range(0, 3) == 0)
            kind = $urandom_range(OP_DIV, OP_POW) == OP_NEG ? OP_POW : OP_DIV;
         else
            kind = 4'($urandom_range(OP_ADD, OP_DEC));
         issue(kind, pick_operand(), pick_operand(), pick_exponent());
      end
   endtask

   initial begin
      logic [31:0] moduli[8];
      moduli = '{32'd1, 32'd0, 32'd2, 32'd12, 32'd1000000007, 32'd3037000499,
                 32'hFFFF_FFFF, 32'd65536};
      quiet         = 1'b0;
      modulus_now   = MODULUS_RESET[31:0];
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = OP_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_exponent  = '0;
      csr_write     = 1'b0;
      csr_modulus   = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset modulus.
      issue(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      issue(OP_SUB, 32'd0, modulus_now - 1, '0);
      issue(OP_MUL, modulus_now - 1, modulus_now - 1, '0);
      issue(OP_DIV, 32'd5, 32'd0, '0);
      issue(OP_DIV, 32'hFFFF_FFFF, 32'd3, '0);
      issue(OP_INV, 32'd0, '0, '0);
      issue(OP_INV, 32'd2, '0, '0);
      issue(OP_NEG, 32'd0, '0, '0);
      issue(OP_NEG, 32'hFFFF_FFFF, '0, '0);
      issue(OP_POW, 32'd2, '0, 64'd0);
      issue(OP_POW, 32'd3, '0, EXP_MAX);
      issue(OP_POW, 32'd3, '0, EXP_MIN);
      issue(OP_POW, 32'd7, '0, -64'sd1);
      issue(OP_POW, 32'd0, '0, -64'sd5);
      issue(OP_POW, 32'd0, '0, 64'd0);
      issue(OP_INC, modulus_now - 1, '0, '0);
      issue(OP_DEC, 32'd0, '0, '0);
      issue(OP_DEC, 32'hFFFF_FFFF, '0, '0);
      issue(KIND_UNUSED_LO, 32'd9, 32'd9, '0);
      issue(KIND_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      random_batch(40);

      // One phase per modulus; the last phase issues its random requests with no idle bursts.
      foreach (moduli[p]) begin
         set_modulus(moduli[p]);
         issue(OP_POW, 32'd0, '0, 64'd0);
         issue(OP_INV, 32'd0, '0, '0);
         if (p == 7) quiet = 1'b1;
         random_batch(55);
      end

      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** modular_arithmetic_unit: PASSED **");
      else
         $display("** modular_arithmetic_unit: FAILED **");
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("** modular_arithmetic_unit: FAILED **");
      $finish;
   end
endmodule
